// ===== src/owm_pkg.sv =====
// Shared types and constants for the single-wire bus master.
// Used by owm_cfg_regs, owm_core and one_wire_bus_master_top; no dependencies.
package owm_pkg;

  localparam int TIMING_BITS    = 10;
  localparam int NUM_REGS       = 8;
  localparam int REG_IDX_BITS   = 3;
  localparam int CFG_INDEX_BITS = 8;
  localparam int BITS_PER_BYTE  = 8;
  localparam int BIT_IDX_BITS   = 3;

  // Timing register indexes
  localparam logic [REG_IDX_BITS-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_RESET_TAIL    = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_WR1_LOW       = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_WR1_RELEASE   = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_WR0_LOW       = 3'd5;
  localparam logic [REG_IDX_BITS-1:0] REG_READ_LOW      = 3'd6;
  localparam logic [REG_IDX_BITS-1:0] REG_READ_TAIL     = 3'd7;

  // Input kind codes
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_RESET = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  typedef logic [NUM_REGS-1:0][TIMING_BITS-1:0] timing_regs_t;

  // Reset values, entry 0 in the lowest bits
  localparam timing_regs_t REG_DEFAULTS = {
    10'd60, 10'd2, 10'd50, 10'd50, 10'd1, 10'd400, 10'd80, 10'd480
  };

  typedef struct packed {
    logic [1:0]               kind;
    logic [BITS_PER_BYTE-1:0] write_byte;
    logic                     line_level;
  } in_item_t;

  typedef struct packed {
    logic                     drive_low;
    logic                     busy_res;
    logic                     done_res;
    logic                     presence_seen;
    logic [BITS_PER_BYTE-1:0] read_result;
    logic                     rejected;
  } res_item_t;

  // A zero timing value counts as one tick
  function automatic logic [TIMING_BITS-1:0] eff_timing(input logic [TIMING_BITS-1:0] v);
    return (v == '0) ? TIMING_BITS'(1) : v;
  endfunction

endpackage

// ===== src/one_wire_bus_master_top.sv =====
// Single-wire bus master: one input word per tick gives one result word.
// An input word is held in the input register, and its result word in the result register.
// Throughput: one word per cycle while m_tready allows; owm_core takes one tick per advance.
// Reset (rst, synchronous, active high) loads default timings, idles the sequencer
// and clears presence; both pipeline registers come up empty.
// Depends on owm_pkg, owm_cfg_regs and owm_core.
module one_wire_bus_master_top (
  input  logic                                clk,
  input  logic                                rst,
  // Input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [15:0]                         s_tdata,   // [7:0] write_byte, [8] line_level
  input  logic [1:0]                          s_tuser,   // [1:0] kind
  // Result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [15:0]                         m_tdata,   // [0] drive_low, [1] busy_res,
                                                         // [2] done_res, [3] presence_seen,
                                                         // [11:4] read_result, [12] rejected
  // Configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [owm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [owm_pkg::TIMING_BITS-1:0]     cfg_data
);
  import owm_pkg::*;

  logic         in_valid;
  in_item_t     in_item;
  logic         advance;
  res_item_t    core_res;
  res_item_t    out_res;
  timing_regs_t timing_regs;

  assign cfg_ready = 1'b1;

  owm_cfg_regs u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .timing_regs (timing_regs)
  );

  // Move a word forward when the result register is free or being drained
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.kind       <= s_tuser;
      in_item.write_byte <= s_tdata[7:0];
      in_item.line_level <= s_tdata[8];
    end
  end

  owm_core u_core (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .item        (in_item),
    .timing_regs (timing_regs),
    .result      (core_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign m_tdata = {3'b000, out_res.rejected, out_res.read_result, out_res.presence_seen,
                    out_res.done_res, out_res.busy_res, out_res.drive_low};

endmodule

// ===== src/owm_cfg_regs.sv =====
// Timing register file for the single-wire bus master.
// Depends on owm_pkg.
module owm_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [owm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [owm_pkg::TIMING_BITS-1:0]     cfg_data,
  output owm_pkg::timing_regs_t               timing_regs
);
  import owm_pkg::*;

  // Load defaults on reset, write in-range indexes only
  always_ff @(posedge clk) begin
    if (rst) begin
      timing_regs <= REG_DEFAULTS;
    end else if (cfg_valid && (cfg_index < CFG_INDEX_BITS'(NUM_REGS))) begin
      timing_regs[cfg_index[REG_IDX_BITS-1:0]] <= cfg_data;
    end
  end

endmodule

// ===== src/owm_core.sv =====
// Phase sequencer of the single-wire bus master: one tick per advance.
// Depends on owm_pkg.
module owm_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  owm_pkg::in_item_t      item,
  input  owm_pkg::timing_regs_t  timing_regs,
  output owm_pkg::res_item_t     result
);
  import owm_pkg::*;

  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_RST_LOW   = 4'd1;
  localparam logic [3:0] PH_RST_WAIT  = 4'd2;
  localparam logic [3:0] PH_RST_TAIL  = 4'd3;
  localparam logic [3:0] PH_WR_LOW    = 4'd4;
  localparam logic [3:0] PH_WR_REL    = 4'd5;
  localparam logic [3:0] PH_RD_LOW    = 4'd6;
  localparam logic [3:0] PH_RD_SAMPLE = 4'd7;
  localparam logic [3:0] PH_RD_TAIL   = 4'd8;

  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_RESET = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [BIT_IDX_BITS-1:0] LAST_BIT = BIT_IDX_BITS'(BITS_PER_BYTE - 1);

  logic [3:0]               phase, phase_next, e_phase;
  logic [1:0]               operation, operation_next, e_op;
  logic [TIMING_BITS-1:0]   tick_count, tick_count_next, e_tick;
  logic [BIT_IDX_BITS-1:0]  bit_index, bit_index_next, e_bit;
  logic [BITS_PER_BYTE-1:0] shift_byte, shift_byte_next, e_shift;
  logic                     presence_flag, presence_flag_next;
  logic [TIMING_BITS-1:0]   len;
  logic                     cur_bit;
  logic                     phase_end;
  logic                     finish;

  // Start a new operation on the same tick, or go on with the current one
  always_comb begin
    e_phase = phase;
    e_op    = operation;
    e_tick  = tick_count;
    e_bit   = bit_index;
    e_shift = shift_byte;
    if (phase == PH_IDLE && item.kind != KIND_TICK) begin
      e_tick = '0;
      e_bit  = '0;
      case (item.kind)
        KIND_RESET: begin
          e_op    = OP_RESET;
          e_phase = PH_RST_LOW;
        end
        KIND_WRITE: begin
          e_op    = OP_WRITE;
          e_phase = PH_WR_LOW;
          e_shift = item.write_byte;
        end
        default: begin
          e_op    = OP_READ;
          e_phase = PH_RD_LOW;
          e_shift = '0;
        end
      endcase
    end
  end

  // Length of the running phase
  assign cur_bit = e_shift[e_bit];

  always_comb begin
    case (e_phase)
      PH_RST_LOW:  len = eff_timing(timing_regs[REG_RESET_LOW]);
      PH_RST_WAIT: len = eff_timing(timing_regs[REG_PRESENCE_WAIT]);
      PH_RST_TAIL: len = eff_timing(timing_regs[REG_RESET_TAIL]);
      PH_WR_LOW:   len = cur_bit ? eff_timing(timing_regs[REG_WR1_LOW])
                                 : eff_timing(timing_regs[REG_WR0_LOW]);
      PH_WR_REL:   len = cur_bit ? eff_timing(timing_regs[REG_WR1_RELEASE])
                                 : TIMING_BITS'(1);
      PH_RD_LOW:   len = eff_timing(timing_regs[REG_READ_LOW]);
      PH_RD_TAIL:  len = eff_timing(timing_regs[REG_READ_TAIL]);
      default:     len = TIMING_BITS'(1);
    endcase
  end

  assign phase_end = ({1'b0, e_tick} + (TIMING_BITS+1)'(1)) >= {1'b0, len};

  // Advance the phase, sample the bus and build the result
  always_comb begin
    phase_next         = e_phase;
    operation_next     = e_op;
    tick_count_next    = e_tick;
    bit_index_next     = e_bit;
    shift_byte_next    = e_shift;
    presence_flag_next = presence_flag;
    finish             = 1'b0;

    result               = '0;
    result.rejected      = (item.kind != KIND_TICK) && (phase != PH_IDLE);

    if (e_phase != PH_IDLE) begin
      result.busy_res  = 1'b1;
      result.drive_low = (e_phase == PH_RST_LOW) || (e_phase == PH_WR_LOW) ||
                         (e_phase == PH_RD_LOW);

      if (e_phase == PH_RST_TAIL && e_tick == '0) begin
        presence_flag_next = ~item.line_level;
      end
      if (e_phase == PH_RD_SAMPLE) begin
        shift_byte_next = e_shift | (BITS_PER_BYTE'(item.line_level) << e_bit);
      end

      if (phase_end) begin
        tick_count_next = '0;
        case (e_phase)
          PH_RST_LOW:   phase_next = PH_RST_WAIT;
          PH_RST_WAIT:  phase_next = PH_RST_TAIL;
          PH_RST_TAIL:  finish = 1'b1;
          PH_WR_LOW:    phase_next = PH_WR_REL;
          PH_WR_REL: begin
            if (e_bit == LAST_BIT) begin
              finish = 1'b1;
            end else begin
              bit_index_next = e_bit + 1'b1;
              phase_next     = PH_WR_LOW;
            end
          end
          PH_RD_LOW:    phase_next = PH_RD_SAMPLE;
          PH_RD_SAMPLE: phase_next = PH_RD_TAIL;
          PH_RD_TAIL: begin
            if (e_bit == LAST_BIT) begin
              finish = 1'b1;
            end else begin
              bit_index_next = e_bit + 1'b1;
              phase_next     = PH_RD_LOW;
            end
          end
          default:      finish = 1'b1;
        endcase
      end else begin
        tick_count_next = e_tick + 1'b1;
      end

      if (finish) begin
        result.done_res = 1'b1;
        if (e_op == OP_READ) begin
          result.read_result = shift_byte_next;
        end
        phase_next      = PH_IDLE;
        operation_next  = OP_NONE;
        tick_count_next = '0;
        bit_index_next  = '0;
      end
    end

    result.presence_seen = presence_flag_next;
  end

  // Hold state between ticks, update on each advance
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      operation     <= OP_NONE;
      tick_count    <= '0;
      bit_index     <= '0;
      shift_byte    <= '0;
      presence_flag <= 1'b0;
    end else if (advance) begin
      phase         <= phase_next;
      operation     <= operation_next;
      tick_count    <= tick_count_next;
      bit_index     <= bit_index_next;
      shift_byte    <= shift_byte_next;
      presence_flag <= presence_flag_next;
    end
  end

endmodule

// ===== sim/one_wire_bus_master_top_test.sv =====
// Self-checking testbench for one_wire_bus_master_top: drives ticks and timing writes,
// predicts every result word per tick and compares it field by field.
// Depends on owm_pkg and one_wire_bus_master_top.
`timescale 1ns / 1ps

module one_wire_bus_master_top_test;
  import owm_pkg::*;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;

  typedef enum logic [3:0] {
    SEQ_IDLE, SEQ_RST_LOW, SEQ_RST_WAIT, SEQ_RST_TAIL,
    SEQ_WR_LOW, SEQ_WR_REL, SEQ_RD_LOW, SEQ_RD_SAMPLE, SEQ_RD_TAIL
  } seq_phase_t;

  typedef enum logic [1:0] {OP_NONE, OP_RESET, OP_WRITE, OP_READ} bus_op_t;

  // Line level modes for directed operations
  localparam int LINE_LOW  = 0;
  localparam int LINE_HIGH = 1;
  localparam int LINE_RAND = 2;

  // Tick-accurate copy of the bus sequencer plus the words it still owes
  class owm_tick_scoreboard;
    logic [TIMING_BITS-1:0]   timings [NUM_REGS];
    seq_phase_t               phase;
    bus_op_t                  op;
    logic [TIMING_BITS-1:0]   ticks;
    logic [BIT_IDX_BITS-1:0]  bit_idx;
    logic [BITS_PER_BYTE-1:0] shifter;
    logic                     presence;
    res_item_t                expected_words [$];
    int                       mismatches;
    int                       words_seen;

    function new();
      for (int i = 0; i < NUM_REGS; i++) timings[i] = REG_DEFAULTS[i];
      phase       = SEQ_IDLE;
      op          = OP_NONE;
      ticks       = '0;
      bit_idx     = '0;
      shifter     = '0;
      presence    = 1'b0;
      mismatches  = 0;
      words_seen  = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [TIMING_BITS-1:0] val);
      // Indexes past the register file are dropped
      if (idx < NUM_REGS) timings[idx[REG_IDX_BITS-1:0]] = val;
    endfunction

    function int slot_len(logic [REG_IDX_BITS-1:0] r);
      return (timings[r] == '0) ? 1 : int'(timings[r]);
    endfunction

    function int phase_ticks();
      logic b;
      b = shifter[bit_idx];
      case (phase)
        SEQ_RST_LOW:  return slot_len(REG_RESET_LOW);
        SEQ_RST_WAIT: return slot_len(REG_PRESENCE_WAIT);
        SEQ_RST_TAIL: return slot_len(REG_RESET_TAIL);
        SEQ_WR_LOW:   return b ? slot_len(REG_WR1_LOW) : slot_len(REG_WR0_LOW);
        SEQ_WR_REL:   return b ? slot_len(REG_WR1_RELEASE) : 1;
        SEQ_RD_LOW:   return slot_len(REG_READ_LOW);
        SEQ_RD_TAIL:  return slot_len(REG_READ_TAIL);
        default:      return 1;
      endcase
    endfunction

    // Advance the sequencer by one tick and return the word it produces
    function res_item_t advance_tick(in_item_t it);
      res_item_t r;
      bit        fin;
      int        len;
      r   = '0;
      fin = 1'b0;
      if (it.kind != KIND_TICK && phase != SEQ_IDLE) r.rejected = 1'b1;

      // Start a new operation; its first tick is this one
      if (phase == SEQ_IDLE && it.kind != KIND_TICK) begin
        ticks   = '0;
        bit_idx = '0;
        case (it.kind)
          KIND_RESET: begin
            op    = OP_RESET;
            phase = SEQ_RST_LOW;
          end
          KIND_WRITE: begin
            op      = OP_WRITE;
            phase   = SEQ_WR_LOW;
            shifter = it.write_byte;
          end
          default: begin
            op      = OP_READ;
            phase   = SEQ_RD_LOW;
            shifter = '0;
          end
        endcase
      end

      if (phase != SEQ_IDLE) begin
        len        = phase_ticks();
        r.busy_res = 1'b1;
        r.drive_low = (phase == SEQ_RST_LOW || phase == SEQ_WR_LOW || phase == SEQ_RD_LOW);
        if (phase == SEQ_RST_TAIL && ticks == '0) presence = ~it.line_level;
        if (phase == SEQ_RD_SAMPLE) shifter[bit_idx] = shifter[bit_idx] | it.line_level;

        if (int'(ticks) + 1 >= len) begin
          ticks = '0;
          case (phase)
            SEQ_RST_LOW:   phase = SEQ_RST_WAIT;
            SEQ_RST_WAIT:  phase = SEQ_RST_TAIL;
            SEQ_WR_LOW:    phase = SEQ_WR_REL;
            SEQ_RD_LOW:    phase = SEQ_RD_SAMPLE;
            SEQ_RD_SAMPLE: phase = SEQ_RD_TAIL;
            SEQ_WR_REL, SEQ_RD_TAIL: begin
              if (bit_idx == BITS_PER_BYTE - 1) begin
                fin = 1'b1;
              end else begin
                bit_idx = bit_idx + 1'b1;
                phase   = (phase == SEQ_WR_REL) ? SEQ_WR_LOW : SEQ_RD_LOW;
              end
            end
            default: fin = 1'b1;
          endcase
        end else begin
          ticks = ticks + 1'b1;
        end

        // Close out the operation on its last tick
        if (fin) begin
          r.done_res = 1'b1;
          if (op == OP_READ) r.read_result = shifter;
          phase   = SEQ_IDLE;
          op      = OP_NONE;
          ticks   = '0;
          bit_idx = '0;
        end
      end
      r.presence_seen = presence;
      return r;
    endfunction

    // Look one tick ahead without disturbing the state
    function res_item_t peek(in_item_t it);
      seq_phase_t               s_phase;
      bus_op_t                  s_op;
      logic [TIMING_BITS-1:0]   s_ticks;
      logic [BIT_IDX_BITS-1:0]  s_bit;
      logic [BITS_PER_BYTE-1:0] s_shift;
      logic                     s_pres;
      res_item_t                r;
      s_phase = phase;
      s_op    = op;
      s_ticks = ticks;
      s_bit   = bit_idx;
      s_shift = shifter;
      s_pres  = presence;
      r = advance_tick(it);
      phase    = s_phase;
      op       = s_op;
      ticks    = s_ticks;
      bit_idx  = s_bit;
      shifter  = s_shift;
      presence = s_pres;
      return r;
    endfunction

    function void note_tick(in_item_t it);
      expected_words.push_back(advance_tick(it));
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 30) $display("MISMATCH: %s", msg);
    endtask

    task check_word(logic [15:0] w);
      res_item_t e;
      res_item_t a;
      words_seen++;
      if (expected_words.size() == 0) begin
        report($sformatf("word %0d arrived with nothing expected: %h", words_seen, w));
        return;
      end
      e = expected_words.pop_front();
      a.drive_low     = w[0];
      a.busy_res      = w[1];
      a.done_res      = w[2];
      a.presence_seen = w[3];
      a.read_result   = w[11:4];
      a.rejected      = w[12];
      if (a !== e || w[15:13] !== 3'b000)
        report($sformatf({"word %0d: got drv=%b busy=%b done=%b pres=%b rd=%h rej=%b pad=%b,",
                          " want drv=%b busy=%b done=%b pres=%b rd=%h rej=%b"},
                         words_seen, a.drive_low, a.busy_res, a.done_res, a.presence_seen,
                         a.read_result, a.rejected, w[15:13], e.drive_low, e.busy_res,
                         e.done_res, e.presence_seen, e.read_result, e.rejected));
    endtask
  endclass

  logic                          clk;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [15:0]                   s_tdata;
  logic [1:0]                    s_tuser;
  logic                          m_tvalid;
  logic                          m_tready;
  logic [15:0]                   m_tdata;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [CFG_INDEX_BITS-1:0]     cfg_index;
  logic [TIMING_BITS-1:0]        cfg_data;

  owm_tick_scoreboard            sb;
  logic [TIMING_BITS-1:0]        plan [NUM_REGS];
  int                            burst_left;
  int                            hold_requests;
  int                            hold_served;
  int                            hold_left;
  int                            stall_mode;
  int                            stall_left;
  int                            cycle_count;

  one_wire_bus_master_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Receiver: stall in changing modes, and hold off entirely on request
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(16, 128);
    end else begin
      stall_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      case (stall_mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= ($urandom_range(0, 3) != 0);
        default: m_tready <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  // Check every accepted result word
  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready) sb.check_word(m_tdata);
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offer one tick word in bursts with random gaps; return once accepted
  task automatic send_tick(logic [1:0] kind, logic [7:0] wbyte, logic line);
    in_item_t it;
    int       gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 64);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    it.kind       = kind;
    it.write_byte = wbyte;
    it.line_level = line;
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {7'b0, line, wbyte};
    do @(posedge clk); while (s_tready !== 1'b1);
    sb.note_tick(it);
  endtask

  // Random tick: mostly start commands when idle, plain ticks when busy,
  // with stray commands while busy and on the finishing tick
  task automatic random_tick();
    logic [1:0]   k;
    logic [7:0]   b;
    logic         ln;
    in_item_t     probe;
    res_item_t    nxt;
    b  = 8'($urandom);
    ln = 1'($urandom);
    if (sb.phase == SEQ_IDLE) begin
      k = ($urandom_range(0, 9) < 8) ? 2'($urandom_range(1, 3)) : KIND_TICK;
    end else begin
      probe.kind       = KIND_TICK;
      probe.write_byte = b;
      probe.line_level = ln;
      nxt = sb.peek(probe);
      if (nxt.done_res && $urandom_range(0, 3) == 0) k = 2'($urandom_range(1, 3));
      else if ($urandom_range(0, 49) == 0)           k = 2'($urandom_range(1, 3));
      else                                            k = KIND_TICK;
    end
    send_tick(k, b, ln);
  endtask

  task automatic random_ticks(int n);
    repeat (n) random_tick();
  endtask

  // Tick until the sequencer is back to idle
  task automatic finish_op();
    while (sb.phase != SEQ_IDLE) send_tick(KIND_TICK, 8'($urandom), 1'($urandom));
  endtask

  // Run one operation start to end with a chosen line level
  task automatic run_op(logic [1:0] kind, logic [7:0] wbyte, int line_mode,
                        bit poke_busy, bit poke_done);
    in_item_t  probe;
    res_item_t nxt;
    logic      ln;
    int        n;
    ln = (line_mode == LINE_RAND) ? 1'($urandom) : (line_mode == LINE_HIGH);
    send_tick(kind, wbyte, ln);
    n = 0;
    while (sb.phase != SEQ_IDLE) begin
      if (line_mode == LINE_RAND) ln = 1'($urandom);
      probe.kind       = KIND_TICK;
      probe.write_byte = ~wbyte;
      probe.line_level = ln;
      nxt = sb.peek(probe);
      if (poke_done && nxt.done_res) send_tick(KIND_WRITE, ~wbyte, ln);
      else if (poke_busy && n == 1)  send_tick(KIND_READ, ~wbyte, ln);
      else                           send_tick(KIND_TICK, ~wbyte, ln);
      n++;
    end
  endtask

  // Stop offering and wait for every owed word, then let the pipeline settle
  task automatic drain_and_settle();
    s_tvalid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_timing(logic [CFG_INDEX_BITS-1:0] idx, logic [TIMING_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.write_reg(idx, val);
  endtask

  task automatic set_plan(int lo, int hi);
    for (int i = 0; i < NUM_REGS; i++) plan[i] = TIMING_BITS'($urandom_range(lo, hi));
  endtask

  // Write the plan (all or a random subset) plus one write past the register file
  task automatic program_timings(bit partial);
    for (int i = 0; i < NUM_REGS; i++)
      if (!partial || $urandom_range(0, 1)) write_timing(CFG_INDEX_BITS'(i), plan[i]);
    write_timing(CFG_INDEX_BITS'($urandom_range(NUM_REGS, 255)), TIMING_BITS'($urandom));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    sb            = new();
    burst_left    = 0;
    hold_requests = 0;
    hold_served   = 0;
    hold_left     = 0;
    stall_mode    = 0;
    stall_left    = 0;
    cycle_count   = 0;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= KIND_TICK;
    m_tready  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset timings: one read with stray commands
    run_op(KIND_READ, 8'hA5, LINE_RAND, 1'b1, 1'b1);
    drain_and_settle();

    // Shortest timings: presence both ways, extreme bytes, stray commands
    set_plan(1, 1);
    program_timings(1'b0);
    run_op(KIND_RESET, 8'hFF, LINE_LOW, 1'b0, 1'b0);
    run_op(KIND_RESET, 8'h00, LINE_HIGH, 1'b1, 1'b1);
    run_op(KIND_WRITE, 8'h00, LINE_LOW, 1'b1, 1'b0);
    run_op(KIND_WRITE, 8'hFF, LINE_HIGH, 1'b0, 1'b1);
    run_op(KIND_READ, 8'h00, LINE_HIGH, 1'b0, 1'b0);
    run_op(KIND_READ, 8'hFF, LINE_LOW, 1'b1, 1'b1);
    send_tick(KIND_TICK, 8'hFF, 1'b1);
    send_tick(KIND_TICK, 8'h00, 1'b0);
    drain_and_settle();

    // Zero timings behave as one tick
    set_plan(0, 0);
    program_timings(1'b0);
    random_ticks(100);
    finish_op();
    drain_and_settle();

    // Small random timings, some only partly rewritten; one long receiver hold
    for (int p = 0; p < 5; p++) begin
      set_plan(1, 6);
      program_timings(p > 0);
      if (p == 2) hold_requests++;
      random_ticks(120);
      finish_op();
      drain_and_settle();
    end

    if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/owm_pkg.sv
src/owm_cfg_regs.sv
src/owm_core.sv
src/one_wire_bus_master_top.sv
sim/one_wire_bus_master_top_test.sv
